>>> rtl/core/stg_pkg.sv
// Shared types and constants of the sine tone generator.
package stg_pkg;

  // Residue, rate and frequency width, then position, amplitude, config, index, index counter and sample widths.
  localparam int unsigned RES_W = 18;
  localparam int unsigned POS_W = 17;
  localparam int unsigned AMP_W = 15;
  localparam int unsigned CFG_W = 18;
  localparam int unsigned IDX_W = 31;
  localparam int unsigned IDX_CNT_W = 5;
  localparam int unsigned SAMPLE_W = 16;

  // Digit-serial multiplier geometry.
  localparam int unsigned MUL_W = 32;
  localparam int unsigned DIGIT_W = 8;
  localparam int unsigned MUL_DIGITS = MUL_W / DIGIT_W;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // Q30 polynomial arithmetic.
  localparam int unsigned Q_FRAC = 30;
  localparam int unsigned Q_W = 31;
  localparam logic [Q_W-1:0] Q30_ONE = 31'd1073741824;
  localparam logic [Q_W-1:0] COEF_C1 = 31'd1686629713;
  localparam logic [Q_W-1:0] COEF_C3 = 31'd693598669;
  localparam logic [Q_W-1:0] COEF_C5 = 31'd85569306;
  localparam logic [Q_W-1:0] COEF_C7 = 31'd5026995;
  localparam logic [Q_W-1:0] COEF_C9 = 31'd172272;
  localparam logic [Q_W-1:0] COEF_C11 = 31'd3864;

  // Register reset values.
  localparam logic [RES_W-1:0] FREQ_RST = 18'd440;
  localparam logic [RES_W-1:0] RATE_RST = 18'd44100;
  localparam logic [AMP_W-1:0] PEAK_RST = 15'd32000;
  localparam logic [POS_W-1:0] LEN_RST = 17'd44100;

  typedef enum logic [1:0] {
    CFG_TONE_FREQ,
    CFG_SAMPLE_RATE,
    CFG_PEAK_AMP,
    CFG_BUFFER_LEN
  } cfg_idx_e;

endpackage

>>> rtl/core/stg_serial_div.sv
// Restoring divider, one quotient bit per cycle.
module stg_serial_div #(
  parameter int unsigned NUM_W = 18
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [stg_pkg::RES_W-1:0] den_i,   // hold steady while busy, nonzero
  input  logic [stg_pkg::RES_W-1:0] rem_i,   // initial remainder, below den_i
  input  logic [NUM_W-1:0]         num_i,
  output logic                     done_o,
  output logic [NUM_W-1:0]         quo_o,
  output logic [stg_pkg::RES_W-1:0] rem_o
);
  import stg_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [RES_W-1:0] rem_q;
  logic [NUM_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [RES_W:0]   trial;
  logic [RES_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_i};
  assign diff  = trial - {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      rem_q  <= rem_i;
      quo_q  <= num_i;
      cnt_q  <= CNT_W'(NUM_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      rem_q  <= ge ? diff[RES_W-1:0] : trial[RES_W-1:0];
      quo_q  <= {quo_q[NUM_W-2:0], ge};
      cnt_q  <= cnt_q - CNT_W'(1);
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/core/stg_digit_mul.sv
// Unsigned multiplier taking one 8-bit digit of the multiplier per cycle.
module stg_digit_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [stg_pkg::MUL_W-1:0]  a_i,
  input  logic [stg_pkg::MUL_W-1:0]  b_i,
  output logic                      done_o,
  output logic [stg_pkg::PROD_W-1:0] prod_o
);
  import stg_pkg::*;

  localparam int unsigned CNT_W = $clog2(MUL_DIGITS + 1);

  logic [MUL_W-1:0]         a_q;
  logic [MUL_W-1:0]         b_q;
  logic [PROD_W-1:0]        acc_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     done_q;
  logic [MUL_W+DIGIT_W-1:0] pp;

  // Partial product of the top remaining digit, MSB first.
  assign pp = {{DIGIT_W{1'b0}}, a_q} * {{MUL_W{1'b0}}, b_q[MUL_W-1 -: DIGIT_W]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      a_q    <= a_i;
      b_q    <= b_i;
      acc_q  <= '0;
      cnt_q  <= CNT_W'(MUL_DIGITS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      acc_q  <= (acc_q << DIGIT_W) + {{(MUL_W - DIGIT_W){1'b0}}, pp};
      b_q    <= b_q << DIGIT_W;
      cnt_q  <= cnt_q - CNT_W'(1);
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

>>> rtl/core/sine_tone_generator.sv
// Sine tone generator: phase residue, serial angle division, sine polynomial.
// Requests are taken one at a time: a new request is accepted only once the previous sample
// has been loaded into the output slot. Steps in order: the residue reductions, the restart
//   multiply when restart is set, the angle quotient, eight digit-serial products, and the
//   emit into the output slot.
// Reset: config returns to 440 Hz / 44100 Hz / 32000 / 44100, phase and position clear.
module sine_tone_generator #(
  parameter int unsigned ANGLE_FRACTION_BITS = 24,
  parameter int unsigned SINE_BITS           = 18
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request stream.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,  // [30:0] start_index, [31] zero
  input  logic                         s_axis_tuser,  // [0] restart
  // Sample stream.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [stg_pkg::SAMPLE_W-1:0] m_axis_tdata,  // [15:0] sample
  output logic                         m_axis_tlast,  // last_of_buffer
  // Register write channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [stg_pkg::CFG_W-1:0]    cfg_data_i
);
  import stg_pkg::*;

  localparam int unsigned AF = ANGLE_FRACTION_BITS;
  localparam logic [SINE_BITS-1:0] M_ONE = SINE_BITS'(1) << (SINE_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_RESTART,
    S_FRAC,
    S_POLY,
    S_DONE
  } state_e;

  // Multiply sequence: square, five Horner steps, angle product, amplitude scale.
  typedef enum logic [2:0] {
    MS_SQUARE,
    MS_C9,
    MS_C7,
    MS_C5,
    MS_C3,
    MS_C1,
    MS_ANGLE,
    MS_SCALE
  } mstep_e;

  // Configuration registers.
  logic [RES_W-1:0] freq_q;
  logic [RES_W-1:0] rate_q;
  logic [AMP_W-1:0] peak_q;
  logic [POS_W-1:0] len_q;

  // Phase and buffer state.
  logic [RES_W-1:0] residue_q;
  logic [POS_W-1:0] pos_q;

  // Per-request working registers.
  state_e               state_q;
  mstep_e               mstep_q;
  logic                 restart_q;
  logic [IDX_W-1:0]     sidx_q;
  logic [IDX_CNT_W-1:0] idx_q;
  logic [RES_W-1:0]     r_q;
  logic [RES_W-1:0]     fm_q;
  logic [1:0]           quad_q;
  logic [Q_W-1:0]       x_q;
  logic [Q_W-1:0]       u_q;
  logic [Q_W-1:0]       p_q;
  logic [SINE_BITS-1:0] m_q;
  logic [SAMPLE_W-1:0]  level_q;
  logic                 red_start_q;
  logic                 ang_start_q;
  logic                 mul_start_q;
  logic                 red_start_d;
  logic                 ang_start_d;
  logic                 mul_start_d;

  // Output register.
  logic                 out_valid_q;
  logic                 out_valid_d;
  logic                 out_load;
  logic [SAMPLE_W-1:0]  out_sample_q;
  logic                 out_last_q;

  // Datapath signals.
  logic [RES_W-1:0]     rate_eff;
  logic [POS_W-1:0]     len_eff;
  logic [RES_W:0]       rate19;
  logic [RES_W:0]       dbl;
  logic [RES_W:0]       dbl_red;
  logic [RES_W:0]       mm_sum;
  logic [RES_W-1:0]     mm_next;
  logic [RES_W:0]       adv_sum;
  logic [RES_W-1:0]     adv_next;
  logic [POS_W-1:0]     pos_cur;
  logic                 is_last;
  logic                 fdiv_done;
  logic                 rdiv_done;
  logic                 adiv_done;
  logic [RES_W-1:0]     fdiv_rem;
  logic [RES_W-1:0]     rdiv_rem;
  logic [AF-1:0]        adiv_quo;
  logic [29:0]          x_low;
  logic [Q_W-1:0]       x_next;
  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic                 mul_done;
  logic [PROD_W-1:0]    mul_prod;
  logic [Q_W-1:0]       prod_q30;
  logic [SINE_BITS-1:0] m_raw;
  logic [SINE_BITS-1:0] m_cap;
  logic [SAMPLE_W-1:0]  mag;

  // A zero rate or buffer length behaves as one.
  assign rate_eff = (rate_q == '0) ? RES_W'(1) : rate_q;
  assign len_eff  = (len_q == '0) ? POS_W'(1) : len_q;
  assign rate19   = {1'b0, rate_eff};

  // Register writes; the user must change config only while the block is idle, the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= FREQ_RST;
      rate_q <= RATE_RST;
      peak_q <= PEAK_RST;
      len_q  <= LEN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TONE_FREQ:   freq_q <= cfg_data_i[RES_W-1:0];
        CFG_SAMPLE_RATE: rate_q <= cfg_data_i[RES_W-1:0];
        CFG_PEAK_AMP:    peak_q <= cfg_data_i[AMP_W-1:0];
        CFG_BUFFER_LEN:  len_q  <= cfg_data_i[POS_W-1:0];
      endcase
    end
  end

  // Frequency and held residue are both reduced modulo the rate each request;
  // the reduced residue is ignored when the request restarts the phase.
  stg_serial_div #(.NUM_W(RES_W)) u_freq_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (red_start_q),
    .den_i   (rate_eff),
    .rem_i   ('0),
    .num_i   (freq_q),
    .done_o  (fdiv_done),
    .quo_o   (),
    .rem_o   (fdiv_rem)
  );

  stg_serial_div #(.NUM_W(RES_W)) u_res_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (red_start_q),
    .den_i   (rate_eff),
    .rem_i   ('0),
    .num_i   (residue_q),
    .done_o  (rdiv_done),
    .quo_o   (),
    .rem_o   (rdiv_rem)
  );

  // Angle fraction: floor(r * 2^AF / rate). Since r < rate, start with r as
  // the remainder and shift in AF zero bits.
  stg_serial_div #(.NUM_W(AF)) u_angle_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ang_start_q),
    .den_i   (rate_eff),
    .rem_i   (r_q),
    .num_i   ('0),
    .done_o  (adiv_done),
    .quo_o   (adiv_quo),
    .rem_o   ()
  );

  // Restart multiply, MSB first: r = 2r + bit*fm, reduced after each add.
  always_comb begin
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= rate19) ? dbl - rate19 : dbl;
    mm_sum  = dbl_red + (sidx_q[IDX_W-1] ? {1'b0, fm_q} : '0);
    mm_next = (mm_sum >= rate19) ? RES_W'(mm_sum - rate19) : mm_sum[RES_W-1:0];
  end

  // Phase advance and buffer position for the sample being finished.
  always_comb begin
    adv_sum  = {1'b0, r_q} + {1'b0, fm_q};
    adv_next = (adv_sum >= rate19) ? RES_W'(adv_sum - rate19) : adv_sum[RES_W-1:0];
    pos_cur  = restart_q ? '0 : pos_q;
    is_last  = pos_cur >= (len_eff - POS_W'(1));
  end

  // Quarter-turn argument in Q30; mirror it in odd quadrants.
  assign x_low  = 30'(adiv_quo[AF-3:0]) << (32 - AF);
  assign x_next = adiv_quo[AF-2] ? (Q30_ONE - {1'b0, x_low}) : {1'b0, x_low};

  // Multiplier operand select per step.
  always_comb begin
    unique case (mstep_q)
      MS_SQUARE: begin
        mul_a = MUL_W'(x_q);
        mul_b = MUL_W'(x_q);
      end
      MS_C9: begin
        mul_a = MUL_W'(COEF_C11);
        mul_b = MUL_W'(u_q);
      end
      MS_C7, MS_C5, MS_C3, MS_C1: begin
        mul_a = MUL_W'(p_q);
        mul_b = MUL_W'(u_q);
      end
      MS_ANGLE: begin
        mul_a = MUL_W'(p_q);
        mul_b = MUL_W'(x_q);
      end
      MS_SCALE: begin
        mul_a = MUL_W'(peak_q);
        mul_b = MUL_W'(m_q);
      end
    endcase
  end

  stg_digit_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // Truncate products by 2^30; sine magnitude keeps SINE_BITS-1 fraction bits.
  assign prod_q30 = mul_prod[Q_FRAC + Q_W - 1 : Q_FRAC];
  assign m_raw    = prod_q30[Q_W-1 -: SINE_BITS];
  assign m_cap    = (m_raw > M_ONE) ? M_ONE : m_raw;
  assign mag      = SAMPLE_W'(mul_prod >> (SINE_BITS - 1));

  // Start strobes for the serial units, and the output slot: load it when the
  // sample is ready and the slot is free or being taken, drop it once taken.
  always_comb begin
    red_start_d = (state_q == S_IDLE) && s_axis_tvalid;
    ang_start_d = ((state_q == S_REDUCE) && rdiv_done && fdiv_done && !restart_q)
               || ((state_q == S_RESTART) && (idx_q == IDX_CNT_W'(1)));
    mul_start_d = ((state_q == S_FRAC) && adiv_done)
               || ((state_q == S_POLY) && mul_done && (mstep_q != MS_SCALE));
    out_load    = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
    out_valid_d = out_load || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mstep_q      <= MS_SQUARE;
      restart_q    <= 1'b0;
      sidx_q       <= '0;
      idx_q        <= '0;
      r_q          <= '0;
      fm_q         <= '0;
      quad_q       <= '0;
      x_q          <= '0;
      u_q          <= '0;
      p_q          <= '0;
      m_q          <= '0;
      level_q      <= '0;
      red_start_q  <= 1'b0;
      ang_start_q  <= 1'b0;
      mul_start_q  <= 1'b0;
      residue_q    <= '0;
      pos_q        <= '0;
      out_valid_q  <= 1'b0;
      out_sample_q <= '0;
      out_last_q   <= 1'b0;
    end else begin
      red_start_q <= red_start_d;
      ang_start_q <= ang_start_d;
      mul_start_q <= mul_start_d;
      out_valid_q <= out_valid_d;

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            restart_q <= s_axis_tuser;
            sidx_q    <= s_axis_tdata[IDX_W-1:0];
            state_q   <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (rdiv_done && fdiv_done) begin
            fm_q <= fdiv_rem;
            if (restart_q) begin
              r_q     <= '0;
              idx_q   <= IDX_CNT_W'(IDX_W);
              state_q <= S_RESTART;
            end else begin
              r_q     <= rdiv_rem;
              state_q <= S_FRAC;
            end
          end
        end
        S_RESTART: begin
          r_q    <= mm_next;
          sidx_q <= sidx_q << 1;
          idx_q  <= idx_q - IDX_CNT_W'(1);
          if (idx_q == IDX_CNT_W'(1)) begin
            state_q <= S_FRAC;
          end
        end
        S_FRAC: begin
          if (adiv_done) begin
            quad_q  <= adiv_quo[AF-1 -: 2];
            x_q     <= x_next;
            mstep_q <= MS_SQUARE;
            state_q <= S_POLY;
          end
        end
        S_POLY: begin
          if (mul_done) begin
            unique case (mstep_q)
              MS_SQUARE: u_q <= prod_q30;
              MS_C9:     p_q <= COEF_C9 - prod_q30;
              MS_C7:     p_q <= COEF_C7 - prod_q30;
              MS_C5:     p_q <= COEF_C5 - prod_q30;
              MS_C3:     p_q <= COEF_C3 - prod_q30;
              MS_C1:     p_q <= COEF_C1 - prod_q30;
              MS_ANGLE:  m_q <= m_cap;
              MS_SCALE:  level_q <= quad_q[1] ? SAMPLE_W'(16'd0 - mag) : mag;
            endcase
            if (mstep_q == MS_SCALE) begin
              state_q <= S_DONE;
            end else begin
              mstep_q <= mstep_e'(mstep_q + 3'd1);
            end
          end
        end
        S_DONE: begin
          // Hold until the output slot is free, then advance phase and position.
          if (out_load) begin
            out_sample_q <= level_q;
            out_last_q   <= is_last;
            residue_q    <= adv_next;
            pos_q        <= is_last ? '0 : pos_cur + POS_W'(1);
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sample_q;
  assign m_axis_tlast  = out_last_q;

endmodule
